// File: hw/rtl/hrht_pkg.sv
// Shared types and constants for the HTTP request head tokenizer.
// Request/response payload structs, parser state, byte codes and method tables.
// No dependencies.
`timescale 1ns / 1ps

package hrht_pkg;

   localparam int VERSION_BYTES = 8;
   localparam int NUM_METHODS   = 5;

   localparam logic [13:0] IDX_MAX          = 14'd16383;
   localparam logic [13:0] MAX_LINE_DEFAULT = 14'd8192;

   localparam logic [63:0] VER_11 = 64'h485454502F312E31;
   localparam logic [63:0] VER_10 = 64'h485454502F312E30;

   localparam logic [7:0] CH_SP    = 8'h20;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_QMARK = 8'h3F;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_H     = 8'h48;
   localparam logic [7:0] CH_ONE   = 8'h31;

   // byte classes
   localparam logic [2:0] CLS_DELIM   = 3'd0;
   localparam logic [2:0] CLS_METHOD  = 3'd1;
   localparam logic [2:0] CLS_PATH    = 3'd2;
   localparam logic [2:0] CLS_QUERY   = 3'd3;
   localparam logic [2:0] CLS_VERSION = 3'd4;
   localparam logic [2:0] CLS_HNAME   = 3'd5;
   localparam logic [2:0] CLS_HVALUE  = 3'd6;

   // event status
   localparam logic [2:0] ST_BUSY     = 3'd0;
   localparam logic [2:0] ST_LINE_OK  = 3'd1;
   localparam logic [2:0] ST_HDR_DONE = 3'd2;
   localparam logic [2:0] ST_COMPLETE = 3'd3;
   localparam logic [2:0] ST_ERROR    = 3'd4;

   // method codes
   localparam logic [2:0] METH_GET    = 3'd0;
   localparam logic [2:0] METH_POST   = 3'd1;
   localparam logic [2:0] METH_HEAD   = 3'd2;
   localparam logic [2:0] METH_PUT    = 3'd3;
   localparam logic [2:0] METH_DELETE = 3'd4;

   // configuration register indexes
   localparam logic REG_MAX_LINE = 1'b0;

   typedef enum logic [9:0] {
      PH_METHOD  = 10'b00_0000_0001,
      PH_SP_PATH = 10'b00_0000_0010,
      PH_PATH    = 10'b00_0000_0100,
      PH_QUERY   = 10'b00_0000_1000,
      PH_SP_VER  = 10'b00_0001_0000,
      PH_VERSION = 10'b00_0010_0000,
      PH_WAIT_LF = 10'b00_0100_0000,
      PH_HEADER  = 10'b00_1000_0000,
      PH_DONE    = 10'b01_0000_0000,
      PH_ERROR   = 10'b10_0000_0000
   } phase_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       start_of_message;
   } req_type;

   typedef struct packed {
      logic [2:0] byte_class;
      logic [2:0] event_status;
      logic [2:0] method_code;
      logic       version_code;
   } rsp_type;

   typedef struct packed {
      phase_type   parse_phase;
      logic [13:0] line_index;
      logic [4:0]  method_match_flags;
      logic [2:0]  method_length;
      logic [63:0] version_buffer;
      logic [3:0]  version_length;
      logic        colon_seen;
      logic        previous_was_cr;
   } parse_state_type;

   localparam parse_state_type STATE_RESTART = '{
      parse_phase:        PH_METHOD,
      line_index:         14'd0,
      method_match_flags: 5'b11111,
      method_length:      3'd0,
      version_buffer:     64'd0,
      version_length:     4'd0,
      colon_seen:         1'b0,
      previous_was_cr:    1'b0
   };

   function automatic logic [2:0] meth_len(input logic [2:0] code);
      case (code)
         METH_GET:    meth_len = 3'd3;
         METH_POST:   meth_len = 3'd4;
         METH_HEAD:   meth_len = 3'd4;
         METH_PUT:    meth_len = 3'd3;
         METH_DELETE: meth_len = 3'd6;
         default:     meth_len = 3'd0;
      endcase
   endfunction

   // method text, left justified in 48 bits
   function automatic logic [47:0] meth_text(input logic [2:0] code);
      case (code)
         METH_GET:    meth_text = {"GET", 24'h0};
         METH_POST:   meth_text = {"POST", 16'h0};
         METH_HEAD:   meth_text = {"HEAD", 16'h0};
         METH_PUT:    meth_text = {"PUT", 24'h0};
         METH_DELETE: meth_text = "DELETE";
         default:     meth_text = 48'h0;
      endcase
   endfunction

   function automatic logic [7:0] meth_char(input logic [2:0] code, input logic [2:0] pos);
      logic [47:0] shifted;
      shifted   = meth_text(code) << {pos, 3'b000};
      meth_char = shifted[47:40];
   endfunction

endpackage

// File: hw/rtl/hrht_step.sv
// Per-byte next-state and result logic of the request head tokenizer.
// Pure combinational; the caller holds the state and result registers. Uses hrht_pkg.
`timescale 1ns / 1ps

module hrht_step import hrht_pkg::*; (
   input  parse_state_type state_cur,
   input  req_type         req,
   input  logic [13:0]     max_line,
   output parse_state_type state_nxt,
   output rsp_type         rsp
);

   always_comb begin
      parse_state_type s;
      logic [7:0]      b;
      logic [2:0]      cls;
      logic [2:0]      st;
      logic [2:0]      mc;
      logic            vc;
      logic            fail;
      logic [4:0]      pick;

      b    = req.data_byte;
      s    = req.start_of_message ? STATE_RESTART : state_cur;
      cls  = CLS_DELIM;
      st   = ST_BUSY;
      mc   = METH_GET;
      vc   = 1'b0;
      fail = 1'b0;
      pick = '0;

      case (s.parse_phase)
         PH_DONE: begin
            st = ST_COMPLETE;
         end
         PH_ERROR: begin
            st = ST_ERROR;
         end
         PH_HEADER: begin
            if (b == CH_LF && s.previous_was_cr) begin
               st = s.colon_seen ? ST_HDR_DONE : ST_COMPLETE;
               if (!s.colon_seen)
                  s.parse_phase = PH_DONE;
               s.colon_seen      = 1'b0;
               s.previous_was_cr = 1'b0;
            end else if (b == CH_CR) begin
               s.previous_was_cr = 1'b1;
            end else begin
               s.previous_was_cr = 1'b0;
               if (!s.colon_seen && b == CH_COLON)
                  s.colon_seen = 1'b1;
               else
                  cls = s.colon_seen ? CLS_HVALUE : CLS_HNAME;
            end
         end
         default: begin
            fail = s.line_index > max_line;
            if (s.line_index < IDX_MAX)
               s.line_index = s.line_index + 14'd1;
            if (!fail) begin
               case (s.parse_phase)
                  PH_METHOD: begin
                     if (b == CH_SP) begin
                        for (int k = 0; k < NUM_METHODS; k++)
                           pick[k] = s.method_match_flags[k] &&
                                     (meth_len(3'(k)) == s.method_length);
                        if (s.method_length == 3'd0 || pick == 5'd0) begin
                           fail = 1'b1;
                        end else begin
                           s.method_match_flags = pick;
                           s.parse_phase        = PH_SP_PATH;
                        end
                     end else if (b == CH_CR || b == CH_LF) begin
                        fail = 1'b1;
                     end else begin
                        cls = CLS_METHOD;
                        for (int k = 0; k < NUM_METHODS; k++)
                           if (s.method_length >= meth_len(3'(k)) ||
                               meth_char(3'(k), s.method_length) != b)
                              s.method_match_flags[k] = 1'b0;
                        if (s.method_length < 3'd7)
                           s.method_length = s.method_length + 3'd1;
                     end
                  end
                  PH_SP_PATH: begin
                     if (b == CH_SLASH) begin
                        cls           = CLS_PATH;
                        s.parse_phase = PH_PATH;
                     end else if (b != CH_SP) begin
                        fail = 1'b1;
                     end
                  end
                  PH_PATH, PH_QUERY: begin
                     if (b == CH_QMARK && s.parse_phase == PH_PATH)
                        s.parse_phase = PH_QUERY;
                     else if (b == CH_SP)
                        s.parse_phase = PH_SP_VER;
                     else if (b == CH_CR || b == CH_LF)
                        fail = 1'b1;
                     else
                        cls = (s.parse_phase == PH_PATH) ? CLS_PATH : CLS_QUERY;
                  end
                  PH_SP_VER: begin
                     if (b == CH_H) begin
                        cls              = CLS_VERSION;
                        s.version_buffer = {56'd0, b};
                        s.version_length = 4'd1;
                        s.parse_phase    = PH_VERSION;
                     end else if (b != CH_SP) begin
                        fail = 1'b1;
                     end
                  end
                  PH_VERSION: begin
                     if (b == CH_CR) begin
                        if (s.version_length == 4'(VERSION_BYTES) &&
                            (s.version_buffer == VER_11 || s.version_buffer == VER_10))
                           s.parse_phase = PH_WAIT_LF;
                        else
                           fail = 1'b1;
                     end else begin
                        cls              = CLS_VERSION;
                        s.version_buffer = {s.version_buffer[55:0], b};
                        if (s.version_length < 4'(VERSION_BYTES + 1))
                           s.version_length = s.version_length + 4'd1;
                     end
                  end
                  PH_WAIT_LF: begin
                     if (b == CH_LF) begin
                        st = ST_LINE_OK;
                        for (int k = NUM_METHODS - 1; k >= 0; k--)
                           if (s.method_match_flags[k])
                              mc = 3'(k);
                        vc                = (s.version_buffer[7:0] == CH_ONE);
                        s.parse_phase     = PH_HEADER;
                        s.line_index      = 14'd0;
                        s.colon_seen      = 1'b0;
                        s.previous_was_cr = 1'b0;
                     end else begin
                        fail = 1'b1;
                     end
                  end
                  default: begin
                     fail = 1'b1;
                  end
               endcase
            end
            if (fail) begin
               s.parse_phase = PH_ERROR;
               cls           = CLS_DELIM;
               st            = ST_ERROR;
            end
         end
      endcase

      state_nxt        = s;
      rsp.byte_class   = cls;
      rsp.event_status = st;
      rsp.method_code  = mc;
      rsp.version_code = vc;
   end

endmodule

// File: hw/rtl/http_request_head_tokenizer.sv
// Top level of the HTTP request head tokenizer: channels, registers, config port.
// Depends on hrht_pkg and hrht_step.
//
// Usage:
//   req channel: one request per byte of the request head (data_byte plus
//   start_of_message, which restarts parsing at the request line with that byte).
//   rsp channel: exactly one result per request, in order: byte class, event
//   status, and method/version codes that are valid with "request line accepted".
//   csr port: APB-style; register 0 at byte address 0 is max_line_length
//   (14 bits, largest byte index allowed in the request line). pready is tied
//   high. Write it only while no request is in flight.
// Timing:
//   A request is captured in an input register; its result is written into the
//   output register (which drives rsp_valid) once it is empty or rsp_stall is
//   low. One request per cycle is sustained while rsp_stall is low; the
//   per-byte state update between the two registers sets that figure.
// Reset (synchronous, active high) empties both registers, returns the parser
// to the start of the request line and loads max_line_length with 8192.
// When rsp_stall is high the result holds; one more request can be accepted
// into the input register, after which req_stall rises until the result drains.
`timescale 1ns / 1ps

module http_request_head_tokenizer import hrht_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic            in_valid_ff;
   req_type         in_data_ff;
   logic            out_valid_ff;
   rsp_type         out_data_ff;
   parse_state_type state_ff;
   parse_state_type state_in;
   rsp_type         rsp_in;
   logic [13:0]     max_line_ff;
   logic            advance;
   logic            req_take;

   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   hrht_step u_step (
      .state_cur (state_ff),
      .req       (in_data_ff),
      .max_line  (max_line_ff),
      .state_nxt (state_in),
      .rsp       (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_take) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take)
         in_data_ff <= req_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         state_ff     <= STATE_RESTART;
      end else begin
         if (advance) begin
            out_valid_ff <= 1'b1;
            state_ff     <= state_in;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance)
         out_data_ff <= rsp_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   // config port
   always_ff @(posedge clock) begin
      if (reset) begin
         max_line_ff <= MAX_LINE_DEFAULT;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
                   csr_paddr[2] == REG_MAX_LINE) begin
         max_line_ff <= csr_pwdata[13:0];
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_MAX_LINE) ? {18'd0, max_line_ff} : 32'd0;

   // only the register index bit of the address is decoded
   logic unused_paddr;
   assign unused_paddr = ^csr_paddr[1:0];

endmodule

// File: bench/testbench.sv
// Self-checking bench for http_request_head_tokenizer: byte stream in, one token per byte out.
// A scoreboard class predicts every token and checks results in order.
// Depends on hrht_pkg and the tokenizer RTL.
`timescale 1ns / 1ps

module testbench;
   import hrht_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int HOLD_CYCLES    = 400;
   localparam int MAX_REPORTS    = 10;

   typedef enum int {TXT_PATH, TXT_QUERY, TXT_NAME, TXT_VALUE} text_kind_type;

   class tokenizer_scoreboard;
      string       method_words[5] = '{"GET", "POST", "HEAD", "PUT", "DELETE"};
      logic [2:0]  method_codes[5] = '{METH_GET, METH_POST, METH_HEAD, METH_PUT, METH_DELETE};
      logic [13:0] max_line;
      phase_type   phase;
      logic [13:0] line_pos;
      logic [4:0]  candidates;
      logic [2:0]  verb_len;
      logic [63:0] ver_word;
      logic [3:0]  ver_count;
      logic        in_value;
      logic        saw_cr;
      rsp_type     expected_tokens[$];
      int          mismatches;
      int          checked;

      function new();
         max_line   = MAX_LINE_DEFAULT;
         mismatches = 0;
         checked    = 0;
         restart();
      endfunction

      function void restart();
         phase      = PH_METHOD;
         line_pos   = '0;
         candidates = '1;
         verb_len   = '0;
         ver_word   = '0;
         ver_count  = '0;
         in_value   = 1'b0;
         saw_cr     = 1'b0;
      endfunction

      function rsp_type tokenize_byte(req_type r);
         rsp_type    res;
         logic [7:0] b;
         logic [4:0] pick;
         logic       fail;
         int         k;
         res  = '0;
         fail = 1'b0;
         b    = r.data_byte;
         if (r.start_of_message) restart();
         if (phase == PH_DONE) begin
            res.event_status = ST_COMPLETE;
         end else if (phase == PH_ERROR) begin
            res.event_status = ST_ERROR;
         end else if (phase == PH_HEADER) begin
            if (b == CH_LF && saw_cr) begin
               res.event_status = in_value ? ST_HDR_DONE : ST_COMPLETE;
               if (!in_value) phase = PH_DONE;
               in_value = 1'b0;
               saw_cr   = 1'b0;
            end else if (b == CH_CR) begin
               saw_cr = 1'b1;
            end else begin
               saw_cr = 1'b0;
               if (!in_value && b == CH_COLON) in_value = 1'b1;
               else res.byte_class = in_value ? CLS_HVALUE : CLS_HNAME;
            end
         end else begin
            if (line_pos > max_line) fail = 1'b1;
            if (line_pos != IDX_MAX) line_pos++;
            if (!fail) begin
               case (phase)
                  PH_METHOD: begin
                     if (b == CH_SP) begin
                        pick = '0;
                        for (k = 0; k < 5; k++)
                           if (candidates[k] && method_words[k].len() == verb_len) pick[k] = 1'b1;
                        if (verb_len == 0 || pick == 0) begin
                           fail = 1'b1;
                        end else begin
                           candidates = pick;
                           phase      = PH_SP_PATH;
                        end
                     end else if (b == CH_CR || b == CH_LF) begin
                        fail = 1'b1;
                     end else begin
                        res.byte_class = CLS_METHOD;
                        for (k = 0; k < 5; k++)
                           if (verb_len >= method_words[k].len()
                               || method_words[k][verb_len] != b) candidates[k] = 1'b0;
                        if (verb_len != 3'd7) verb_len++;
                     end
                  end
                  PH_SP_PATH: begin
                     if (b == CH_SLASH) begin
                        res.byte_class = CLS_PATH;
                        phase          = PH_PATH;
                     end else if (b != CH_SP) begin
                        fail = 1'b1;
                     end
                  end
                  PH_PATH, PH_QUERY: begin
                     if (b == CH_QMARK && phase == PH_PATH) phase = PH_QUERY;
                     else if (b == CH_SP) phase = PH_SP_VER;
                     else if (b == CH_CR || b == CH_LF) fail = 1'b1;
                     else res.byte_class = (phase == PH_PATH) ? CLS_PATH : CLS_QUERY;
                  end
                  PH_SP_VER: begin
                     if (b == CH_H) begin
                        res.byte_class = CLS_VERSION;
                        ver_word       = {56'd0, b};
                        ver_count      = 4'd1;
                        phase          = PH_VERSION;
                     end else if (b != CH_SP) begin
                        fail = 1'b1;
                     end
                  end
                  PH_VERSION: begin
                     if (b == CH_CR) begin
                        if (ver_count == VERSION_BYTES && (ver_word == VER_11 || ver_word == VER_10))
                           phase = PH_WAIT_LF;
                        else
                           fail = 1'b1;
                     end else begin
                        res.byte_class = CLS_VERSION;
                        ver_word       = {ver_word[55:0], b};
                        if (ver_count < VERSION_BYTES + 1) ver_count++;
                     end
                  end
                  PH_WAIT_LF: begin
                     if (b == CH_LF) begin
                        res.event_status = ST_LINE_OK;
                        for (k = 4; k >= 0; k--)
                           if (candidates[k]) res.method_code = method_codes[k];
                        res.version_code = (ver_word[7:0] == CH_ONE);
                        phase    = PH_HEADER;
                        line_pos = '0;
                        in_value = 1'b0;
                        saw_cr   = 1'b0;
                     end else begin
                        fail = 1'b1;
                     end
                  end
                  default: ;
               endcase
            end
            if (fail) begin
               phase            = PH_ERROR;
               res.byte_class   = CLS_DELIM;
               res.event_status = ST_ERROR;
            end
         end
         return res;
      endfunction

      function void note_request(req_type r);
         expected_tokens.push_back(tokenize_byte(r));
      endfunction

      function void flag(string msg);
         mismatches++;
         if (mismatches <= MAX_REPORTS) $display("%s", msg);
      endfunction

      function void compare_field(string name, logic [3:0] want, logic [3:0] got);
         if (got !== want)
            flag($sformatf("token %0d: %s expected %0d got %0d", checked, name, want, got));
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (expected_tokens.size() == 0) begin
            flag($sformatf("token %0d: unexpected result %h", checked, got));
            checked++;
            return;
         end
         want = expected_tokens.pop_front();
         compare_field("byte_class", 4'(want.byte_class), 4'(got.byte_class));
         compare_field("event_status", 4'(want.event_status), 4'(got.event_status));
         compare_field("method_code", 4'(want.method_code), 4'(got.method_code));
         compare_field("version_code", 4'(want.version_code), 4'(got.version_code));
         checked++;
      endfunction

      function int pending();
         return expected_tokens.size();
      endfunction
   endclass

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_valid   = 1'b0;
   logic        req_stall;
   req_type     req_data    = '0;
   logic        rsp_valid;
   logic        rsp_stall   = 1'b0;
   rsp_type     rsp_data;
   logic        csr_psel    = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite  = 1'b0;
   logic [2:0]  csr_paddr   = '0;
   logic [31:0] csr_pwdata  = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   tokenizer_scoreboard sb = new();

   logic [7:0] head_q[$];
   int bytes_sent     = 0;
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int hold_requests  = 0;
   int hold_served    = 0;
   int hold_left      = 0;
   int quiet_cycles   = 0;

   http_request_head_tokenizer u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) sb.note_request(req_data);
         if (rsp_valid && !rsp_stall) sb.check_result(rsp_data);
      end
   end

   // receiver: random stall, or a long hold-off on request
   always @(posedge clock) begin
      if (hold_served != hold_requests) begin
         hold_served = hold_requests;
         hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   function automatic logic [7:0] pick_byte(text_kind_type kind);
      logic [7:0] b;
      do begin
         b = ($urandom_range(9) < 8) ? 8'($urandom_range(8'h7E, 8'h21)) : 8'($urandom_range(255));
      end while (b == CH_CR || b == CH_LF
                 || ((kind == TXT_PATH || kind == TXT_QUERY) && b == CH_SP)
                 || (kind == TXT_PATH && b == CH_QMARK)
                 || (kind == TXT_NAME && b == CH_COLON));
      return b;
   endfunction

   task automatic push_text(input string s);
      int i;
      for (i = 0; i < s.len(); i++) head_q.push_back(8'(s[i]));
   endtask

   task automatic send_byte(input logic [7:0] value, input logic first);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{data_byte: value, start_of_message: first};
      do @(posedge clock); while (req_stall);
      bytes_sent++;
   endtask

   task automatic send_queue(input logic som);
      int i;
      for (i = 0; i < head_q.size(); i++) send_byte(head_q[i], (i == 0) ? som : 1'b0);
      head_q.delete();
   endtask

   // one request head: mostly well formed, some broken or pure noise
   task automatic build_head();
      string word;
      int    pos;
      int    keep;
      head_q.delete();
      if ($urandom_range(99) < 8) begin
         repeat ($urandom_range(6, 1)) head_q.push_back(8'($urandom_range(255)));
         return;
      end
      word = sb.method_words[$urandom_range(4)];
      if ($urandom_range(99) < 6)
         word = $urandom_range(1) ? word.substr(0, word.len() - 2) : {word, "S"};
      push_text(word);
      repeat ($urandom_range(2, 1)) head_q.push_back(CH_SP);
      head_q.push_back(CH_SLASH);
      repeat (($urandom_range(99) < 5) ? $urandom_range(60, 20) : $urandom_range(8))
         head_q.push_back(pick_byte(TXT_PATH));
      if ($urandom_range(1)) begin
         head_q.push_back(CH_QMARK);
         repeat ($urandom_range(6)) head_q.push_back(pick_byte(TXT_QUERY));
      end
      repeat ($urandom_range(2, 1)) head_q.push_back(CH_SP);
      case ($urandom_range(19))
         0: push_text("HTTP/1.2");
         1: push_text("HTTP/1.");
         2: push_text("HTTP/1.10");
         3: push_text("HTTPS/1.1");
         default: push_text($urandom_range(1) ? "HTTP/1.1" : "HTTP/1.0");
      endcase
      push_text(($urandom_range(19) == 0) ? "\rX" : "\r\n");
      repeat ($urandom_range(4)) begin
         repeat ($urandom_range(6)) head_q.push_back(pick_byte(TXT_NAME));
         head_q.push_back(CH_COLON);
         repeat ($urandom_range(10)) begin
            case ($urandom_range(15))
               0: begin
                  head_q.push_back(CH_CR);
                  head_q.push_back(pick_byte(TXT_VALUE));
               end
               1: head_q.push_back(CH_LF);
               default: head_q.push_back(pick_byte(TXT_VALUE));
            endcase
         end
         push_text("\r\n");
      end
      if ($urandom_range(9) == 0)
         repeat ($urandom_range(5, 1)) head_q.push_back(pick_byte(TXT_NAME));
      push_text("\r\n");
      if ($urandom_range(99) < 12) begin
         pos = $urandom_range(head_q.size() - 1);
         case ($urandom_range(7))
            0: head_q[pos] = CH_CR;
            1: head_q[pos] = CH_LF;
            2: head_q[pos] = CH_SP;
            3: head_q[pos] = CH_QMARK;
            4: head_q[pos] = CH_COLON;
            5: head_q[pos] = CH_SLASH;
            6: head_q[pos] = CH_H;
            default: head_q[pos] = 8'($urandom_range(255));
         endcase
      end
      if ($urandom_range(99) < 5) begin
         keep = $urandom_range(head_q.size(), 1);
         while (head_q.size() > keep) void'(head_q.pop_back());
      end
      repeat ($urandom_range(2)) head_q.push_back(8'($urandom_range(255)));
   endtask

   task automatic run_phase(input int send_pct, input int recv_pct, input int count,
                            input bit squeeze);
      int target;
      target         = bytes_sent + count;
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
      if (squeeze) hold_requests++;
      while (bytes_sent < target) begin
         build_head();
         send_queue($urandom_range(99) >= 3);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_max_line(input logic [13:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {REG_MAX_LINE, 2'b00};
      csr_pwdata  <= 32'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      sb.max_line = value;
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // CR in method, then sticky error
      push_text("\r");
      head_q.push_back(8'hFF);
      send_queue(1'b1);
      // unknown method
      head_q.push_back(8'h00);
      head_q.push_back(CH_SP);
      send_queue(1'b1);
      // empty method
      push_text(" ");
      send_queue(1'b1);
      // bad path start, LF in query, bad version start
      push_text("GET x");
      send_queue(1'b1);
      push_text("PUT /?\n");
      send_queue(1'b1);
      push_text("HEAD / X");
      send_queue(1'b1);

      run_phase(0, 0, 385, 1'b0);
      drain();
      write_max_line(14'd16);
      run_phase(49, 0, 385, 1'b0);
      drain();
      write_max_line(IDX_MAX);
      run_phase(0, 49, 385, 1'b1);
      drain();
      write_max_line(14'($urandom_range(60, 17)));
      run_phase(16, 16, 385, 1'b0);
      drain();
      write_max_line(14'd200);
      run_phase(0, 0, 385, 1'b0);
      drain();

      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// File: files.f
hw/rtl/hrht_pkg.sv
hw/rtl/hrht_step.sv
hw/rtl/http_request_head_tokenizer.sv
bench/testbench.sv
